// ----- rtl/core/double_ended_queue_unit_macros.svh -----
// Assertion macros used by the deque RTL.
// DQU_CHECK checks a property on every clock edge outside of reset.
// DQU_CHECK_ALWAYS checks a property on every clock edge, reset included.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DQU_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DQU_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DQU_CHECK(lbl, prop, msg)
`define DQU_CHECK_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/dqu_pkg.sv -----
`default_nettype none
package dqu_pkg;

  // Request codes carried on the input tuser.
  typedef enum logic [3:0] {
    REQ_PUSH_FRONT = 4'd0,
    REQ_PUSH_BACK  = 4'd1,
    REQ_POP_FRONT  = 4'd2,
    REQ_POP_BACK   = 4'd3,
    REQ_MOD_FRONT  = 4'd4,
    REQ_MOD_BACK   = 4'd5,
    REQ_PEEK_FRONT = 4'd6,
    REQ_PEEK_BACK  = 4'd7,
    REQ_CLEAR      = 4'd8
  } req_t;

  localparam int unsigned REQ_W = 4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic shift_r;    // push front: every cell takes its left neighbor
    logic shift_l;    // pop front: every cell takes its right neighbor
    logic wr_back;    // push back: first empty cell takes the new element
    logic drop_back;  // pop back: last occupied cell empties
    logic mod_front;  // overwrite the head cell
    logic mod_back;   // overwrite the last occupied cell
    logic clr;        // empty every cell
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/dqu_cell.sv -----
`default_nettype none
module dqu_cell
  import dqu_pkg::*;
#(
  parameter int unsigned DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic [DATA_W-1:0] din,
  input  wire logic              head,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic              left_valid,
  input  wire logic [DATA_W-1:0] right_data,
  input  wire logic              right_valid,
  output logic      [DATA_W-1:0] data,
  output logic                   valid,
  output logic      [DATA_W-1:0] back_tap
);

  logic              valid_next;
  logic [DATA_W-1:0] data_next;
  logic              last;
  logic              slot;

  // The occupied cells always form an unbroken run starting at the head.
  assign last = valid & ~right_valid;
  assign slot = ~valid & left_valid;

  assign back_tap = last ? data : '0;

  always_comb begin
    valid_next = valid;
    if (cmd.clr) begin
      valid_next = 1'b0;
    end else if (cmd.shift_r) begin
      valid_next = left_valid;
    end else if (cmd.shift_l) begin
      valid_next = right_valid;
    end else if (cmd.wr_back && slot) begin
      valid_next = 1'b1;
    end else if (cmd.drop_back && last) begin
      valid_next = 1'b0;
    end
  end

  always_comb begin
    data_next = data;
    if (cmd.shift_r) begin
      data_next = left_data;
    end else if (cmd.shift_l) begin
      data_next = right_data;
    end else if ((cmd.wr_back && slot) || (cmd.mod_front && head) ||
                 (cmd.mod_back && last)) begin
      data_next = din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

// ----- rtl/core/dqu_tree.sv -----
`default_nettype none
module dqu_tree
  import dqu_pkg::*;
#(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic [DATA_W-1:0] leaf [DEPTH],
  output logic      [DATA_W-1:0] root
);

  localparam int unsigned LVL   = $clog2(DEPTH);
  localparam int unsigned LEAVES = 1 << LVL;
  localparam int unsigned NODES = 2 * LEAVES - 1;

  // Heap-ordered OR tree, one register level per tree level. At most one
  // leaf is nonzero, so the root carries that leaf once it has passed every level.
  logic [DATA_W-1:0] node [NODES];

  for (genvar k = 0; k < NODES; k++) begin : gen_node
    if (k < LEAVES - 1) begin : gen_inner
      always_ff @(posedge clk) begin
        node[k] <= node[2*k+1] | node[2*k+2];
      end
    end else if (k - (LEAVES - 1) < DEPTH) begin : gen_leaf
      always_ff @(posedge clk) begin
        node[k] <= leaf[k-(LEAVES-1)];
      end
    end else begin : gen_pad
      always_ff @(posedge clk) begin
        node[k] <= '0;
      end
    end
  end

  assign root = node[0];

endmodule
`default_nettype wire

// ----- rtl/core/double_ended_queue_unit.sv -----
// Every request except pop back and peek back has its result in the result
// register in the cycle after it is taken; those two pass through the
// registered OR tree that gathers the back element out of the cell row.
// Throughput: one item per cycle for front, push, modify and clear requests
// while the result register is free or being emptied; a back read on a nonempty
// queue holds s_tready low until its result is registered, so no new item is taken.
// Reset (rst, synchronous, active high) empties every cell and the count.
`default_nettype none
`include "double_ended_queue_unit_macros.svh"
module double_ended_queue_unit
  import dqu_pkg::*;
#(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // s_tdata: data_in, zero padded to whole bytes.
  input  wire logic [((DATA_W+7)/8)*8-1:0] s_tdata,
  // s_tuser: req_type.
  input  wire logic [REQ_W-1:0] s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // m_tdata: data_out, status, occupancy, is_empty, from the lowest bit up,
  // zero padded to whole bytes.
  output logic [((DATA_W+2+$clog2(DEPTH+1)+1+7)/8)*8-1:0] m_tdata
);

  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
  localparam int unsigned LVL    = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(LVL + 1);
  localparam int unsigned OUT_TW = ((DATA_W + 2 + OCC_W + 1 + 7) / 8) * 8;

  // The queue lives in a row of cells, the front element always in cell 0
  // and the occupied cells forming an unbroken run. Push front and pop front
  // shift the whole row by one place; pop back and modify back act on the last
  // cell of the run, found from its right neighbor's valid bit, and push back
  // fills the first empty cell, found from its left neighbor's valid bit.
  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic              cell_valid [DEPTH];
  logic [DATA_W-1:0] back_tap   [DEPTH];
  logic [DATA_W-1:0] lft_data   [DEPTH];
  logic              lft_valid  [DEPTH];
  logic [DATA_W-1:0] rgt_data   [DEPTH];
  logic              rgt_valid  [DEPTH];
  logic [DEPTH-1:0]  valid_vec;

  state_t            state;
  state_t            state_next;
  logic [CW-1:0]     wait_cnt;
  logic [OCC_W-1:0]  count;
  logic [OCC_W-1:0]  count_next;

  logic [DATA_W-1:0] out_data;
  status_t           out_status;
  logic [OCC_W-1:0]  out_occ;
  logic              out_empty;

  logic              accept;
  logic              tree_done;
  logic              empty;
  logic              full;
  cmd_t              cmd;
  cmd_t              cell_cmd;
  status_t           req_status;
  logic              front_rd;
  logic              back_rd;
  logic [DATA_W-1:0] din;
  logic [DATA_W-1:0] back_data;
  req_t              req;

  assign din    = s_tdata[DATA_W-1:0];
  assign req    = req_t'(s_tuser);
  assign accept = s_tvalid & s_tready;
  assign empty  = (count == '0);
  assign full   = (count == OCC_W'(DEPTH));

  // Request decode. Requests that hit an empty or full queue leave the cells
  // alone and only report their error.
  always_comb begin
    cmd        = '0;
    req_status = ST_OK;
    count_next = count;
    front_rd   = 1'b0;
    back_rd    = 1'b0;
    case (req)
      REQ_PUSH_FRONT: begin
        if (full) begin
          req_status = ST_FULL;
        end else begin
          cmd.shift_r = 1'b1;
          count_next  = count + OCC_W'(1);
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          req_status = ST_FULL;
        end else begin
          cmd.wr_back = 1'b1;
          count_next  = count + OCC_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          req_status = ST_EMPTY;
        end else begin
          cmd.shift_l = 1'b1;
          front_rd    = 1'b1;
          count_next  = count - OCC_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          req_status = ST_EMPTY;
        end else begin
          cmd.drop_back = 1'b1;
          back_rd       = 1'b1;
          count_next    = count - OCC_W'(1);
        end
      end
      REQ_MOD_FRONT: begin
        if (empty) begin
          req_status = ST_EMPTY;
        end else begin
          cmd.mod_front = 1'b1;
        end
      end
      REQ_MOD_BACK: begin
        if (empty) begin
          req_status = ST_EMPTY;
        end else begin
          cmd.mod_back = 1'b1;
        end
      end
      REQ_PEEK_FRONT: begin
        if (empty) begin
          req_status = ST_EMPTY;
        end else begin
          front_rd = 1'b1;
        end
      end
      REQ_PEEK_BACK: begin
        if (empty) begin
          req_status = ST_EMPTY;
        end else begin
          back_rd = 1'b1;
        end
      end
      REQ_CLEAR: begin
        cmd.clr    = 1'b1;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign cell_cmd = accept ? cmd : '0;

  // Cell 0 sees the incoming element as its left neighbor, so a push front
  // shifts it straight in; the last cell sees an empty right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : gen_cell
    if (i == 0) begin : gen_first
      assign lft_data[i]  = din;
      assign lft_valid[i] = 1'b1;
    end else begin : gen_mid_l
      assign lft_data[i]  = cell_data[i-1];
      assign lft_valid[i] = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : gen_last
      assign rgt_data[i]  = '0;
      assign rgt_valid[i] = 1'b0;
    end else begin : gen_mid_r
      assign rgt_data[i]  = cell_data[i+1];
      assign rgt_valid[i] = cell_valid[i+1];
    end
    assign valid_vec[i] = cell_valid[i];

    dqu_cell #(
      .DATA_W(DATA_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cell_cmd),
      .din        (din),
      .head       (i == 0),
      .left_data  (lft_data[i]),
      .left_valid (lft_valid[i]),
      .right_data (rgt_data[i]),
      .right_valid(rgt_valid[i]),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .back_tap   (back_tap[i])
    );
  end

  // Only the last occupied cell drives a nonzero tap. The tree samples the
  // taps on every edge; the sample taken at the accepting edge, before a pop
  // back empties the cell, then climbs the register levels to the root.
  dqu_tree #(
    .DEPTH (DEPTH),
    .DATA_W(DATA_W)
  ) u_tree (
    .clk (clk),
    .leaf(back_tap),
    .root(back_data)
  );

  // Sequencer: idle, or waiting for the back element to leave the tree.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && back_rd) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (wait_cnt == '0) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // An item is taken only when idle and the result register is free or is
  // being emptied at the same edge.
  always_comb begin
    s_tready  = 1'b0;
    tree_done = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = ~m_tvalid | m_tready;
      end
      S_WAIT: begin
        tree_done = (wait_cnt == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wait_cnt <= '0;
      count    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
      end
      if (accept && back_rd) begin
        wait_cnt <= CW'(LVL);
      end else if (state == S_WAIT && wait_cnt != '0) begin
        wait_cnt <= wait_cnt - CW'(1);
      end
    end
  end

  // Result register. Status and occupancy are known at the accepting edge;
  // a back read fills in the data once the tree delivers it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((accept && !back_rd) || tree_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= req_status;
      out_occ    <= count_next;
      out_empty  <= (count_next == '0);
      out_data   <= front_rd ? cell_data[0] : '0;
    end else if (tree_done) begin
      out_data <= back_data;
    end
  end

  assign m_tdata = OUT_TW'({out_empty, out_occ, out_status, out_data});

  `DQU_CHECK(a_count_bound, count <= OCC_W'(DEPTH), "element count exceeds depth")
  `DQU_CHECK(a_cells_match_count, $countones(valid_vec) == count,
             "occupied cells disagree with element count")
  `DQU_CHECK(a_no_take_in_wait, state == S_WAIT |-> !s_tready,
             "item taken while a back read is in flight")
  `DQU_CHECK(a_tree_result, tree_done |=> m_tvalid,
             "back read finished without presenting its result")
  `DQU_CHECK(a_refused_push, accept && full && (req == REQ_PUSH_FRONT ||
             req == REQ_PUSH_BACK) |=> count == $past(count),
             "refused push changed the element count")

endmodule
`default_nettype wire

// ----- test/deque_result_checker.sv -----
`default_nettype none
module deque_result_checker
  import dqu_pkg::*;
#(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  input  wire logic [((DATA_W+7)/8)*8-1:0] s_tdata,
  input  wire logic [REQ_W-1:0] s_tuser,
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  input  wire logic [((DATA_W+2+$clog2(DEPTH+1)+1+7)/8)*8-1:0] m_tdata,
  output int                    pending_results,
  output int                    mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  typedef struct packed {
    logic                is_empty;
    logic [OCC_W-1:0]    occupancy;
    status_t             status;
    logic [DATA_W-1:0]   data_out;
  } deque_result_t;

  // Shadow model of the deque, kept as a ring buffer. DEPTH is a power of
  // two, so index arithmetic wraps by truncation.
  logic [DATA_W-1:0] shadow_store [DEPTH];
  logic [IDX_W-1:0]  shadow_head;
  logic [OCC_W-1:0]  shadow_count;

  deque_result_t expected_results [$];

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic deque_result_t apply_request(logic [REQ_W-1:0] code,
                                                  logic [DATA_W-1:0] value);
    deque_result_t res;
    logic [IDX_W-1:0] back_idx;
    logic empty_now;
    res = '0;
    res.status = ST_OK;
    back_idx = IDX_W'(shadow_head + shadow_count - 1);
    empty_now = (shadow_count == 0);
    case (code)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          res.status = ST_FULL;
        end else if (code == REQ_PUSH_FRONT) begin
          shadow_head = shadow_head - 1'b1;
          shadow_store[shadow_head] = value;
          shadow_count++;
        end else begin
          shadow_store[IDX_W'(shadow_head + shadow_count)] = value;
          shadow_count++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (empty_now) begin
          res.status = ST_EMPTY;
        end else if (code == REQ_POP_FRONT) begin
          res.data_out = shadow_store[shadow_head];
          shadow_head = shadow_head + 1'b1;
          shadow_count--;
        end else begin
          res.data_out = shadow_store[back_idx];
          shadow_count--;
        end
      end
      REQ_MOD_FRONT, REQ_MOD_BACK: begin
        if (empty_now) res.status = ST_EMPTY;
        else shadow_store[code == REQ_MOD_FRONT ? shadow_head : back_idx] = value;
      end
      REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (empty_now) res.status = ST_EMPTY;
        else res.data_out = shadow_store[code == REQ_PEEK_FRONT ? shadow_head : back_idx];
      end
      REQ_CLEAR: begin
        shadow_head  = '0;
        shadow_count = '0;
      end
      default: ;
    endcase
    res.occupancy = shadow_count;
    res.is_empty  = (shadow_count == 0);
    return res;
  endfunction

  // Requests are taken before results so that a result leaving on the same
  // edge as its own request would still find its expectation.
  always @(posedge clk) begin : watch
    deque_result_t got, want;
    if (rst) begin
      shadow_head  = '0;
      shadow_count = '0;
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_request(s_tuser, s_tdata[DATA_W-1:0]));
      if (m_tvalid && m_tready) begin
        got = deque_result_t'(m_tdata[DATA_W+2+OCC_W:0]);
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0h with none expected", got));
        end else begin
          want = expected_results.pop_front();
          if (got.data_out !== want.data_out)
            report_mismatch($sformatf("data_out got %0h expected %0h",
                                      got.data_out, want.data_out));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      got.status, want.status));
          if (got.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy got %0d expected %0d",
                                      got.occupancy, want.occupancy));
          if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %0b expected %0b",
                                      got.is_empty, want.is_empty));
        end
      end
    end
    pending_results = expected_results.size();
  end

endmodule
`default_nettype wire

// ----- test/tb_double_ended_queue_unit.sv -----
`default_nettype none
module tb_double_ended_queue_unit
  import dqu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned S_TDATA_W = ((DATA_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((DATA_W + 2 + $clog2(DEPTH + 1) + 1 + 7) / 8) * 8;

  // Highest code the request field can carry. Codes above clear are unused
  // and must leave the queue alone.
  localparam logic [REQ_W-1:0] REQ_CODE_MAX = 4'd15;

  localparam int RANDOM_ITEMS = 1026;
  // Idle chance per cycle, in percent, on both sides.
  localparam int IDLE_PCT = 23;
  // Length of the long receiver hold-off, long enough to back the block up.
  localparam int LONG_HOLD_CYCLES = 150;
  // Back reads run through the register levels of the OR tree; drain with margin.
  localparam int DRAIN_CYCLES = $clog2(DEPTH) + 8;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // s_tdata: data_in.
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  // s_tuser: req_type.
  logic [REQ_W-1:0]      s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // m_tdata: data_out, status, occupancy, is_empty.
  logic [M_TDATA_W-1:0]  m_tdata;

  int pending_results;
  int mismatch_count;

  // Shared between the sender and the receiver: idle_on enables random gaps
  // on both sides, hold_request asks the receiver for one long hold-off.
  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;

  always #4 clk = ~clk;

  double_ended_queue_unit #(
    .DEPTH (DEPTH),
    .DATA_W(DATA_W)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  deque_result_checker #(
    .DEPTH (DEPTH),
    .DATA_W(DATA_W)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .pending_results(pending_results),
    .mismatch_count (mismatch_count)
  );

  // Offers one request and returns at the edge where it is taken. A random
  // gap may come first; valid drops only for the gap, so back-to-back items
  // keep it high without lowering it in between.
  task automatic send_request(logic [REQ_W-1:0] code, logic [DATA_W-1:0] value);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= S_TDATA_W'(value);
    do @(posedge clk); while (!s_tready);
  endtask

  // Drops valid and waits until every result in flight has been taken. The
  // extra edge lets the checker log the item accepted on the last one.
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
  endtask

  // Element values lean toward the extremes now and then, so that both
  // all-zero and all-one words pass through every slot.
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DATA_W'({$urandom, $urandom});
  endfunction

  // Chooses a request with a bias set by the phase: growing phases push
  // more than they pop, shrinking ones the reverse, so the occupancy swings
  // between empty and full. Clear and the unused codes come in rarely.
  function automatic logic [REQ_W-1:0] pick_request(int phase);
    int r;
    int push_pct;
    int pop_pct;
    bit at_back;
    r        = $urandom_range(99);
    at_back  = 1'($urandom_range(1));
    push_pct = (phase == 0) ? 60 : (phase == 1) ? 15 : 30;
    pop_pct  = (phase == 0) ? 15 : (phase == 1) ? 60 : 30;
    if (r < 1) return REQ_CLEAR;
    if (r < 3) return REQ_W'($urandom_range(REQ_CODE_MAX, REQ_CLEAR + 1));
    r = $urandom_range(99);
    if (r < push_pct) return at_back ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    if (r < push_pct + pop_pct) return at_back ? REQ_POP_BACK : REQ_POP_FRONT;
    r = $urandom_range(2);
    if (r == 0) return at_back ? REQ_MOD_BACK : REQ_MOD_FRONT;
    return at_back ? REQ_PEEK_BACK : REQ_PEEK_FRONT;
  endfunction

  // Receiver: random back-pressure, a quiet stretch while idle_on is low,
  // and one long hold-off counted here while the sender keeps offering.
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: far beyond the slowest legal run, even with every back read
  // and every gap.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int sent;
    int phase;
    int burst;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue: reads and overwrites report the empty error and change
    // nothing. Clear and an unused code are legal on an empty queue.
    send_request(REQ_POP_FRONT,  '1);
    send_request(REQ_POP_BACK,   '1);
    send_request(REQ_PEEK_FRONT, '0);
    send_request(REQ_MOD_BACK,   '1);
    send_request(REQ_CLEAR,      '1);
    send_request(REQ_CODE_MAX,   '1);

    // Fill to the bound from both ends. The first front push wraps the head
    // below slot zero; the extremes of the data go in first.
    for (int i = 0; i < DEPTH; i++) begin
      send_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                   (i == 0) ? '0 : (i == 1) ? '1 : pick_value());
    end

    // Full queue: both pushes are refused with the full error.
    send_request(REQ_PUSH_FRONT, '1);
    send_request(REQ_PUSH_BACK,  '0);

    // Random phases of random length. Along the way the receiver holds off
    // for a long stretch, the sender pauses once for a full drain, and a
    // stretch runs with no idling on either side.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase = $urandom_range(2);
      burst = $urandom_range(8, 40);
      repeat (burst) begin
        if (sent == 200) hold_request = 1'b1;
        if (sent == 500) wait_for_drain();
        if (sent == 650) idle_on = 1'b0;
        if (sent == 850) idle_on = 1'b1;
        send_request(pick_request(phase), pick_value());
        sent++;
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
